### rtl/mitm_pkg.sv
// Package for the modular inverse to Montgomery block.
// Holds the controller state type, datapath command/status structs and register indexes.
// No dependencies.
package mitm_pkg;

    localparam int unsigned FIELD_W = 62;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_RMODM   = 2'd1;
    localparam logic [IDX_W-1:0] REG_BARRETT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_FINAL,
        ST_MONT1,
        ST_MONT2,
        ST_MONT3,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic qmul;
        logic acc;
        logic final_sel;
        logic mont1;
        logic mont2;
        logic mont3;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic rem_zero;
        logic div_last;
        logic mul_last;
    } t_status;

endpackage

### rtl/modular_inverse_to_montgomery.sv
// Top level of the modular inverse to Montgomery form block.
// Instantiates mitm_ctrl and mitm_datapath; depends on mitm_pkg.
//
// Usage: write modulus, r_mod_m and r_mod_m_barrett through the write port
// (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle. Raise start with
// i_value when busy is low; the item is taken at that edge. The result appears
// on o_inverse_mont and o_status for one cycle with o_valid high.
// Each Euclid round runs a bit-serial divider producing one quotient bit a
// cycle, a multiplier built from half-width partial products and an update.
// The conversion takes three such products. busy drops in the same cycle that
// the result appears, so the next item can be taken at the end of that cycle.
// Reset returns the controller to idle and loads the register reset values.
// The receiver cannot stall: each result is shown for exactly one cycle.
module modular_inverse_to_montgomery #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mitm_pkg::FIELD_W-1:0]  i_value,
    input  logic                          i_cfg_we,
    input  logic [mitm_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [mitm_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [mitm_pkg::FIELD_W-1:0]  o_inverse_mont,
    output logic                          o_status
);
    import mitm_pkg::*;

    logic [FIELD_W-1:0] r_modulus, r_rmodm;
    logic [CFG_W-1:0]   r_barrett;
    t_cmd               cmd;
    t_status            sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= FIELD_W'(3);
            r_rmodm   <= FIELD_W'(1);
            r_barrett <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS: r_modulus <= i_cfg_data[FIELD_W-1:0];
                REG_RMODM:   r_rmodm   <= i_cfg_data[FIELD_W-1:0];
                REG_BARRETT: r_barrett <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    mitm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (sts),
        .o_cmd    (cmd)
    );

    mitm_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (sts),
        .i_value        (i_value),
        .i_modulus      (r_modulus),
        .i_r_mod_m      (r_rmodm),
        .i_barrett      (r_barrett),
        .o_inverse_mont (o_inverse_mont),
        .o_status_bit   (o_status),
        .o_valid        (o_valid)
    );
endmodule

### rtl/mitm_datapath.sv
// Datapath of the modular inverse block: Euclid registers, bit-serial divider,
// split multiplier steps and Barrett conversion. Depends on mitm_pkg.
module mitm_datapath #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mitm_pkg::t_cmd                i_cmd,
    output mitm_pkg::t_status             o_status,
    input  logic [mitm_pkg::FIELD_W-1:0]  i_value,
    input  logic [mitm_pkg::FIELD_W-1:0]  i_modulus,
    input  logic [mitm_pkg::FIELD_W-1:0]  i_r_mod_m,
    input  logic [mitm_pkg::CFG_W-1:0]    i_barrett,
    output logic [mitm_pkg::FIELD_W-1:0]  o_inverse_mont,
    output logic                          o_status_bit,
    output logic                          o_valid
);
    import mitm_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH);
    localparam int unsigned HW = WIDTH / 2;
    localparam int unsigned LW = WIDTH - HW;

    logic [WIDTH-1:0] r_m, r_ra, r_rb, r_sa, r_sb;
    logic [WIDTH-1:0] r_quo, r_rem, r_num, r_acc;
    logic [CW-1:0]    r_cnt;
    logic [2*WIDTH-1:0] r_prod;
    logic [WIDTH-1:0] r_inv, r_est;
    logic [FIELD_W-1:0] r_out;
    logic             r_st, r_vld, r_par;
    logic [1:0]       r_pcnt;

    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH-1:0] mulx, muly;
    logic [LW-1:0]    part_a, part_b;
    logic [2*LW-1:0]  part_p;
    logic [2*WIDTH-1:0] part_sh;
    logic [2*WIDTH-1:0] prod;
    logic [WIDTH-1:0] res, ressub;
    logic             mul_step;

    assign rem_sh = {r_rem[WIDTH-2:0], r_num[WIDTH-1]};
    assign trial  = {r_rem[WIDTH-1], rem_sh} - {1'b0, r_rb};

    assign mul_step = i_cmd.qmul | i_cmd.mont1 | i_cmd.mont2 | i_cmd.mont3;

    // Shared multiplier: quotient times coefficient, then Barrett products.
    always_comb begin
        mulx = r_quo;
        muly = r_sb;
        if (i_cmd.mont1) begin
            mulx = i_barrett[WIDTH-1:0];
            muly = r_inv;
        end else if (i_cmd.mont2) begin
            mulx = r_inv;
            muly = WIDTH'(i_r_mod_m);
        end else if (i_cmd.mont3) begin
            mulx = r_est;
            muly = r_m;
        end
    end

    // One half-width partial product per cycle, accumulated in r_prod into the full product.
    always_comb begin
        case (r_pcnt)
            2'd0: begin
                part_a = mulx[LW-1:0];
                part_b = muly[LW-1:0];
            end
            2'd1: begin
                part_a = mulx[LW-1:0];
                part_b = LW'(muly[WIDTH-1:LW]);
            end
            2'd2: begin
                part_a = LW'(mulx[WIDTH-1:LW]);
                part_b = muly[LW-1:0];
            end
            default: begin
                part_a = LW'(mulx[WIDTH-1:LW]);
                part_b = LW'(muly[WIDTH-1:LW]);
            end
        endcase
        part_p = (2*LW)'(part_a) * (2*LW)'(part_b);
        case (r_pcnt)
            2'd0:    part_sh = (2*WIDTH)'(part_p);
            2'd1:    part_sh = (2*WIDTH)'(part_p) << LW;
            2'd2:    part_sh = (2*WIDTH)'(part_p) << LW;
            default: part_sh = (2*WIDTH)'(part_p) << (2*LW);
        endcase
        prod = ((r_pcnt == 2'd0) ? '0 : r_prod) + part_sh;
    end

    assign res    = r_acc - r_prod[WIDTH-1:0];
    assign ressub = res - r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_pcnt <= '0;
        end else begin
            r_vld <= i_cmd.done;
            if (mul_step) begin
                r_pcnt <= r_pcnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m   <= WIDTH'(i_modulus);
            r_ra  <= WIDTH'(i_value);
            r_rb  <= WIDTH'(i_modulus) - WIDTH'(i_value);
            r_sa  <= WIDTH'(1);
            r_sb  <= WIDTH'(1);
            r_par <= 1'b0;
        end
        if (i_cmd.div_start) begin
            r_num <= r_ra;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (!trial[WIDTH]) begin
                r_rem <= trial[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
        if (mul_step) begin
            r_prod <= prod;
        end
        if (i_cmd.acc) begin
            r_ra  <= r_rb;
            r_rb  <= r_rem;
            r_sa  <= r_sb;
            r_sb  <= r_sa + r_prod[WIDTH-1:0];
            r_par <= ~r_par;
        end
        if (i_cmd.final_sel) begin
            r_inv <= r_par ? (r_m - r_sa) : r_sa;
        end
        if (i_cmd.mont2 && r_pcnt == 2'd0) begin
            r_est <= r_prod[2*WIDTH-1:WIDTH];
        end
        if (i_cmd.mont3 && r_pcnt == 2'd0) begin
            r_acc <= r_prod[WIDTH-1:0];
        end
        if (i_cmd.done) begin
            r_st  <= (r_ra != WIDTH'(1));
            r_out <= '0;
            if (r_ra == WIDTH'(1)) begin
                r_out <= FIELD_W'((res >= r_m) ? ressub : res);
            end
        end
    end

    assign o_status.rem_zero = (r_rb == '0);
    assign o_status.div_last = (r_cnt == CW'(WIDTH - 1));
    assign o_status.mul_last = (r_pcnt == 2'd3);
    assign o_inverse_mont    = r_out;
    assign o_status_bit      = r_st;
    assign o_valid           = r_vld;

    // Swapped pairs replace the toggle index; the final coefficient sits in r_sa
    // and gets negated when the round count is odd, tracked by r_par.
endmodule

### rtl/mitm_ctrl.sv
// Controller state machine for the modular inverse block.
// Sequences Euclid rounds, division steps and the conversion. Depends on mitm_pkg.
module mitm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  mitm_pkg::t_status  i_status,
    output mitm_pkg::t_cmd     o_cmd
);
    import mitm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_CHECK;
            ST_CHECK: n_state = i_status.rem_zero ? ST_FINAL : ST_DIV;
            ST_DIV:   if (i_status.div_last) n_state = ST_MUL;
            ST_MUL:   if (i_status.mul_last) n_state = ST_ACC;
            ST_ACC:   n_state = ST_CHECK;
            ST_FINAL: n_state = ST_MONT1;
            ST_MONT1: if (i_status.mul_last) n_state = ST_MONT2;
            ST_MONT2: if (i_status.mul_last) n_state = ST_MONT3;
            ST_MONT3: if (i_status.mul_last) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.load = i_start;
            ST_CHECK: o_cmd.div_start = !i_status.rem_zero;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_MUL:   o_cmd.qmul = 1'b1;
            ST_ACC:   o_cmd.acc = 1'b1;
            ST_FINAL: o_cmd.final_sel = 1'b1;
            ST_MONT1: o_cmd.mont1 = 1'b1;
            ST_MONT2: o_cmd.mont2 = 1'b1;
            ST_MONT3: o_cmd.mont3 = 1'b1;
            ST_DONE:  o_cmd.done = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("more than one datapath command");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_LOAD) else $error("load did not start item");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !o_busy) else $error("busy after done");
endmodule
